@@ design/wsm_pkg.sv @@
// wsm_pkg: widths, polynomial constants and shape codes for the waveform
// shape morph pipeline. No dependencies.
`default_nettype none

package wsm_pkg;

    localparam int PHASE_W  = 32;
    localparam int MORPH_W  = 8;
    localparam int SAMPLE_W = 32;

    // register stages in the pipeline
    localparam int NSTG = 6;

    // polynomial sine, Q12 result
    localparam int SIN_X_W   = 14;              // offset angle within a half circle
    localparam int SIN_SQ_W  = 15;              // (d*d) >> 12, up to 16384
    localparam int SIN_Y_W   = 15;              // inner term, 16384..19900
    localparam int SIN_OUT_W = 14;              // signed Q12, -4096..4096
    localparam int SIN_SHIFT = 17;

    localparam logic [SIN_X_W-1:0]   SIN_X_OFS = 14'h2000;
    localparam logic [SIN_Y_W-1:0]   SIN_B     = 15'd19900;
    localparam logic [11:0]          SIN_C     = 12'd3516;
    localparam logic [SIN_OUT_W-1:0] SIN_ONE   = 14'd4096;

    localparam logic [PHASE_W-1:0]  QUARTER = 32'h4000_0000;

    // shapes after the >> 8 ahead of the crossfade
    localparam int SHAPE_W = 24;
    localparam logic signed [SHAPE_W-1:0] PULSE_HI = 24'sh1F_FFFF;
    localparam logic signed [SHAPE_W-1:0] PULSE_LO = -24'sh20_0000;

    localparam logic [MORPH_W-1:0] FADE_MAX = 8'd255;

    typedef enum logic [1:0] {
        SH_SINE  = 2'd0,
        SH_SAW   = 2'd1,
        SH_TRI   = 2'd2,
        SH_PULSE = 2'd3
    } t_shape;

endpackage

`default_nettype wire

@@ design/waveform_shape_morph.sv @@
// waveform_shape_morph: morphing oscillator waveshaper, six-stage pipeline.
// Depends on wsm_pkg.
//
//   channel | handshake          | beat fields
//   --------+--------------------+---------------------------
//   in      | i_valid / o_ready  | i_phase[31:0], i_morph[7:0]
//   out     | o_valid / i_ready  | o_sample[31:0] (signed)
//
// Six register stages, one beat per cycle sustained while i_ready stays high;
// the depth is set by the three dependent multiplies of the sine polynomial
// plus shape select, weighting and sum.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage holds while the one after it is full and stalled; bubbles
// collapse, so input is taken while a result waits if any stage is empty.
`default_nettype none

module waveform_shape_morph (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [wsm_pkg::PHASE_W-1:0]         i_phase,
    input  wire logic [wsm_pkg::MORPH_W-1:0]         i_morph,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [wsm_pkg::SAMPLE_W-1:0]      o_sample
);
    import wsm_pkg::*;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: d squared, morph split
    logic signed [SIN_X_W-1:0]     w_d;
    logic signed [2*SIN_X_W-1:0]   w_dd;
    logic [9:0]                    w_t;
    logic [MORPH_W-1:0]            w_frac;
    logic [MORPH_W-1:0]            n_f;

    assign w_d    = $signed(i_phase[SIN_SHIFT+SIN_X_W-1:SIN_SHIFT] - SIN_X_OFS);
    assign w_dd   = w_d * w_d;
    assign w_t    = {1'b0, i_morph, 1'b0} + {2'b00, i_morph};
    assign w_frac = w_t[7:0];
    assign n_f    = (w_frac != '0 && w_frac != FADE_MAX) ? w_frac + 8'd1 : w_frac;

    logic [SIN_SQ_W-1:0]  r1_sq;
    logic [PHASE_W-1:0]   r1_phase;
    logic [1:0]           r1_idx;
    logic [MORPH_W-1:0]   r1_f;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_sq    <= w_dd[SIN_SQ_W+11:12];
            r1_phase <= i_phase;
            r1_idx   <= w_t[9:8];
            r1_f     <= n_f;
        end
    end

    // ---------------- stage 2: inner polynomial term
    logic [SIN_SQ_W+11:0] w_p2;
    assign w_p2 = 27'(r1_sq) * 27'(SIN_C);

    logic [SIN_SQ_W-1:0]  r2_sq;
    logic [SIN_Y_W-1:0]   r2_y;
    logic [PHASE_W-1:0]   r2_phase;
    logic [1:0]           r2_idx;
    logic [MORPH_W-1:0]   r2_f;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r2_sq    <= r1_sq;
            r2_y     <= SIN_B - 15'(w_p2[SIN_SQ_W+11:14]);
            r2_phase <= r1_phase;
            r2_idx   <= r1_idx;
            r2_f     <= r1_f;
        end
    end

    // ---------------- stage 3: outer term, half-circle sign
    logic [SIN_SQ_W+SIN_Y_W-1:0] w_p3;
    logic [SIN_OUT_W-1:0]        w_y2;
    assign w_p3 = 30'(r2_sq) * 30'(r2_y);
    assign w_y2 = SIN_ONE - w_p3[SIN_OUT_W+15:16];

    logic signed [SIN_OUT_W-1:0] r3_sine;
    logic [PHASE_W-1:0]          r3_phase;
    logic [1:0]                  r3_idx;
    logic [MORPH_W-1:0]          r3_f;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_sine  <= r2_phase[PHASE_W-1] ? $signed(-w_y2) : $signed(w_y2);
            r3_phase <= r2_phase;
            r3_idx   <= r2_idx;
            r3_f     <= r2_f;
        end
    end

    // ---------------- stage 4: build shapes, pick the pair
    logic signed [PHASE_W-1:0] w_sin32;
    logic signed [PHASE_W-1:0] w_sin_s;
    logic signed [PHASE_W-1:0] w_saw_s;
    logic [PHASE_W-1:0]        w_tri_a;
    logic signed [PHASE_W-1:0] w_tri_s;
    logic signed [SHAPE_W-1:0] w_sh [4];
    logic signed [SHAPE_W-1:0] w_lo;
    logic signed [SHAPE_W-1:0] w_hi;

    assign w_sin32 = PHASE_W'(r3_sine) <<< SIN_SHIFT;
    assign w_sin_s = w_sin32 >>> 8;
    assign w_saw_s = $signed(r3_phase) >>> 10;
    assign w_tri_a = (r3_phase[PHASE_W-1] ? ~r3_phase : r3_phase) - QUARTER;
    assign w_tri_s = $signed(w_tri_a) >>> 9;

    assign w_sh[SH_SINE]  = w_sin_s[SHAPE_W-1:0];
    assign w_sh[SH_SAW]   = w_saw_s[SHAPE_W-1:0];
    assign w_sh[SH_TRI]   = w_tri_s[SHAPE_W-1:0];
    assign w_sh[SH_PULSE] = r3_phase[PHASE_W-1] ? PULSE_LO : PULSE_HI;

    always_comb begin
        case (r3_idx)
            SH_SINE: begin
                w_lo = w_sh[SH_SINE];
                w_hi = w_sh[SH_SAW];
            end
            SH_SAW: begin
                w_lo = w_sh[SH_SAW];
                w_hi = w_sh[SH_TRI];
            end
            default: begin
                // index tops out at triangle/pulse
                w_lo = w_sh[SH_TRI];
                w_hi = w_sh[SH_PULSE];
            end
        endcase
    end

    logic signed [SHAPE_W-1:0] r4_lo;
    logic signed [SHAPE_W-1:0] r4_hi;
    logic [MORPH_W-1:0]        r4_wlo;
    logic [MORPH_W-1:0]        r4_whi;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r4_lo  <= w_lo;
            r4_hi  <= w_hi;
            r4_wlo <= FADE_MAX - r3_f;
            r4_whi <= r3_f;
        end
    end

    // ---------------- stage 5: weight both shapes
    logic signed [SAMPLE_W:0] w_plo;
    logic signed [SAMPLE_W:0] w_phi;
    assign w_plo = r4_lo * $signed({1'b0, r4_wlo});
    assign w_phi = r4_hi * $signed({1'b0, r4_whi});

    logic signed [SAMPLE_W-1:0] r5_plo;
    logic signed [SAMPLE_W-1:0] r5_phi;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_plo <= w_plo[SAMPLE_W-1:0];
            r5_phi <= w_phi[SAMPLE_W-1:0];
        end
    end

    // ---------------- stage 6: sum, output register
    logic signed [SAMPLE_W-1:0] r6_sample;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r6_sample <= r5_plo + r5_phi;
        end
    end

    assign o_sample = r6_sample;

`ifndef SYNTHESIS
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v[0])
        else $error("accepted beat did not reach first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] && r_v[NSTG-2] && !i_ready |=> r_v[NSTG-2] && r_v[NSTG-1])
        else $error("stalled pipeline dropped a beat");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r3_sine <= 14'sd4096) && (r3_sine >= -14'sd4096))
        else $error("sine polynomial out of range");

    a_pair_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> r3_idx != SH_PULSE)
        else $error("pair index beyond triangle");
`endif

endmodule

`default_nettype wire

@@ tb/tb_waveform_shape_morph.sv @@
// tb_waveform_shape_morph: self-checking bench for the waveform shape morph pipeline.
// Needs wsm_pkg and waveform_shape_morph; every sample is predicted here and checked in order.
module tb_waveform_shape_morph;
    import wsm_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 11;
    localparam int N_RANDOM     = 2000;
    localparam int N_CALM       = 300;      // final beats with no idling on either side
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    localparam int POLY_B        = 19900;
    localparam int POLY_C        = 3516;
    localparam int POLY_ONE      = 4096;
    localparam int PHASE_QUARTER = 32'h4000_0000;
    localparam int PULSE_TOP     = 32'h1FFF_FFFF;
    localparam int PULSE_BOTTOM  = -536870912;
    localparam int FADE_FULL     = 255;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [MORPH_W-1:0]  morph;
        logic [SAMPLE_W-1:0] sample;
    } t_sample_exp;

    class morph_sample_tracker;
        t_sample_exp pending[$];
        int unsigned checked;
        int unsigned mismatches;

        function new();
            checked    = 0;
            mismatches = 0;
        endfunction

        // x: top 15 phase bits; Q12 sine
        function int sine_q12(logic [14:0] x);
            logic [13:0] ofs;
            int d, sq, y;
            ofs = x[13:0] - 14'h2000;
            d   = int'($signed(ofs));
            sq  = (d * d) >>> 12;
            y   = POLY_B - ((sq * POLY_C) >>> 14);
            y   = POLY_ONE - ((sq * y) >>> 16);
            return x[14] ? -y : y;
        endfunction

        function int shape_at(t_shape k, logic [PHASE_W-1:0] ph);
            int p, q;
            p = $signed(ph);
            case (k)
                SH_SINE:  return sine_q12(ph[31:17]) << SIN_SHIFT;
                SH_SAW:   return p >>> 2;
                SH_TRI: begin
                    q = ph[31] ? ~p : p;
                    return (q - PHASE_QUARTER) >>> 1;
                end
                default:  return ph[31] ? PULSE_BOTTOM : PULSE_TOP;
            endcase
        endfunction

        function logic [SAMPLE_W-1:0] predict_sample(logic [PHASE_W-1:0] ph,
                                                     logic [MORPH_W-1:0] mo);
            int t, pair, f;
            longint lo, hi, acc;
            t    = int'(mo) * 3;
            pair = t >> 8;
            if (pair > 2) pair = 2;
            f = t & 255;
            // weight nudged up inside the open range so the top end reaches full scale
            if (f > 0 && f < FADE_FULL) f = f + 1;
            lo  = longint'(shape_at(t_shape'(pair), ph) >>> 8);
            hi  = longint'(shape_at(t_shape'(pair + 1), ph) >>> 8);
            acc = lo * (FADE_FULL - f) + hi * f;
            return acc[31:0];
        endfunction

        function void note_phase_beat(logic [PHASE_W-1:0] ph, logic [MORPH_W-1:0] mo);
            t_sample_exp e;
            e.phase  = ph;
            e.morph  = mo;
            e.sample = predict_sample(ph, mo);
            pending.push_back(e);
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] got);
            t_sample_exp e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("sample %h arrived with no beat outstanding", got);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got !== e.sample) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("sample mismatch: phase %h morph %0d expected %h got %h",
                             e.phase, e.morph, e.sample, got);
            end
        endfunction
    endclass

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic [PHASE_W-1:0]         i_phase = '0;
    logic [MORPH_W-1:0]         i_morph = '0;
    logic                       i_ready = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_sample;

    morph_sample_tracker tracker = new();
    int cycle_count   = 0;
    int beats_in      = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int stall_left    = 0;

    waveform_shape_morph DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_phase  (i_phase),
        .i_morph  (i_morph),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_sample (o_sample)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                tracker.note_phase_beat(i_phase, i_morph);
                beats_in++;
            end
            if (o_valid && i_ready)
                tracker.check_sample(o_sample);
        end
    end

    // receiver back-pressure in bursts of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(99) < out_stall_pct) begin
            stall_left = $urandom_range(14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [PHASE_W-1:0] ph, input logic [MORPH_W-1:0] mo);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_phase <= ph;
        i_morph <= mo;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d samples outstanding",
                 cycle_count, tracker.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned k, gap;
        logic [PHASE_W-1:0] ph;
        logic [MORPH_W-1:0] mo;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        out_stall_pct = 10;
        // morph 0 is the only point with zero weight on the upper shape: pure sine at 255/256 gain
        send_beat(32'h0000_0000, 8'd0);
        send_beat(32'hFFFF_FFFF, 8'd0);
        send_beat(32'h8000_0000, 8'd0);
        send_beat(32'h7FFF_FFFF, 8'd0);
        send_beat(32'h4000_0000, 8'd0);
        send_beat(32'hC000_0000, 8'd0);
        send_beat(32'h0002_0000, 8'd0);
        // top of the sine/saw pair, and into saw/triangle
        send_beat(32'h8000_0000, 8'd85);
        send_beat(32'h7FFF_FFFF, 8'd85);
        send_beat(32'h1234_5678, 8'd86);
        send_beat(32'hFFFF_FFFF, 8'd86);
        send_beat(32'h0000_0000, 8'd1);
        // either side of the saw/triangle to triangle/pulse edge, full morph, then mixed points
        send_beat(32'h8000_0000, 8'd171);
        send_beat(32'h7FFF_FFFF, 8'd170);
        send_beat(32'hFFFF_FFFF, 8'd255);
        send_beat(32'h0000_0000, 8'd255);
        send_beat(32'h4000_0000, 8'd255);
        send_beat(32'hC000_0000, 8'd128);
        send_beat(32'h3FFF_FFFF, 8'd64);
        send_beat(32'hBFFF_FFFF, 8'd192);
        send_beat(32'h6000_0000, 8'd42);
        send_beat(32'hE000_0000, 8'd213);
        send_beat(32'hAAAA_AAAA, 8'h55);
        send_beat(32'h5555_5555, 8'hAA);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 100 == 0) begin
                if (k >= N_RANDOM - N_CALM) begin
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end else begin
                    case ($urandom_range(2))
                        0:       in_gap_pct = 0;
                        1:       in_gap_pct = 10;
                        default: in_gap_pct = 35;
                    endcase
                    case ($urandom_range(2))
                        0:       out_stall_pct = 0;
                        1:       out_stall_pct = 10;
                        default: out_stall_pct = 35;
                    endcase
                end
            end

            ph = $urandom;
            case ($urandom_range(7))
                0: ph = {ph[31:30], 30'h0} + $urandom_range(8) - 32'd4;  // near a quadrant edge
                1: ph = {ph[31], {31{ph[30]}}};
                default: ;
            endcase
            mo = 8'($urandom_range(255));
            case ($urandom_range(11))
                0: mo = 8'd0;
                1: mo = 8'd85;
                2: mo = 8'd86;
                3: mo = 8'd170;
                4: mo = 8'd171;
                5: mo = 8'd255;
                default: ;
            endcase

            if ($urandom_range(99) < in_gap_pct) begin
                gap = $urandom_range(1, 15);
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            send_beat(ph, mo);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d phase beats across all three shape pairs, %0d samples checked",
                 beats_in, tracker.checked);
        $display("%0d mismatches, %0d cycles including random idling and back-pressure",
                 tracker.mismatches, cycle_count);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
